// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file salru_checker.sv.
// Depends on nothing; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held low
`define SALRU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that is also checked during reset
`define SALRU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/salru_pkg.sv =====
// Shared types and constants for the set-associative LRU cache tracker.
// No dependencies; used by the interfaces and by every module but salru_queue.
package salru_pkg;

    // payload widths fixed by the word format
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // recency age, 0 = most recent
    typedef logic [1:0] t_age;
    localparam t_age AGE_MAX = 2'd3;

    // access commands
    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_LOAD   = 2'd0;
    localparam t_cmd CMD_STORE  = 2'd1;
    localparam t_cmd CMD_MODIFY = 2'd2;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_SET_BITS   = 2'd0;
    localparam t_cfg_idx REG_WAYS       = 2'd1;
    localparam t_cfg_idx REG_BLOCK_BITS = 2'd2;

    // live cache geometry
    typedef struct packed {
        logic [2:0] set_bits;
        logic [2:0] ways;
        logic [4:0] block_bits;
    } t_cfg;

endpackage

// ===== sv/salru_in_if.sv =====
// Request channel: command and byte address with valid/ready.
// Depends on salru_pkg.
interface salru_in_if;
    import salru_pkg::*;

    logic                valid;
    logic                ready;
    t_cmd                command;
    logic [ADDR_W-1:0]   address;

    modport source (output valid, command, address, input ready);
    modport sink   (input valid, command, address, output ready);
endinterface

// ===== sv/salru_out_if.sv =====
// Result channel: per-word counts and running totals with valid/ready.
// Depends on salru_pkg.
interface salru_out_if;
    import salru_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         hit_count;
    logic               missed;
    logic               evicted;
    logic [CNT_W-1:0]   total_hits;
    logic [CNT_W-1:0]   total_misses;
    logic [CNT_W-1:0]   total_evictions;

    modport source (output valid, hit_count, missed, evicted, total_hits, total_misses,
                     total_evictions, input ready);
    modport sink   (input valid, hit_count, missed, evicted, total_hits, total_misses,
                    total_evictions, output ready);
    modport mon    (input valid, ready, hit_count, missed, evicted, total_hits,
                    total_misses, total_evictions);
endinterface

// ===== sv/set_assoc_lru_cache_tracker_top.sv =====
// Set-associative LRU cache tracker, top level.
// Words arrive on i_req (command, address) and leave on o_rsp: per-word hit
// count, miss and eviction flags, and saturating running totals.
// Geometry registers (set bits, ways, block bits) are written through the
// i_cfg_* port; write them only while no word is in flight.
// After reset the set memory is swept clear, one set per cycle, through all
// 2**MAX_SET_BITS sets (64 by default); i_req.ready stays low meanwhile.
// In the lookup engine each word first has its set row read from the set
// memory (ISSUE), then its tags compared, ages updated and the row written
// back (EVAL). A modify takes the same path, its second access hitting the
// line just touched. The result register loads as EVAL ends. A 2-deep queue
// sits between the front end and the engine, and the result register holds
// its word while o_rsp.ready is low; the engine then stalls and the queue
// fills before i_req.ready drops.
// Depends on salru_pkg, salru_in_if, salru_out_if, salru_front,
// salru_queue and salru_back.
module set_assoc_lru_cache_tracker_top #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 4,
    parameter int ADDR_BITS    = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  salru_pkg::t_cfg_idx                    i_cfg_idx,
    input  logic [salru_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    salru_in_if.sink                               i_req,
    salru_out_if.source                            o_rsp
);
    import salru_pkg::*;

    localparam int SIW     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int QW      = $bits(t_cmd) + SIW + ADDR_BITS;
    localparam int Q_DEPTH = 2;

    t_cfg                 r_cfg;
    logic                 push;
    logic                 pop;
    logic                 q_valid;
    logic                 q_full;
    logic                 clearing;
    t_cmd                 f_cmd;
    logic [SIW-1:0]       f_set;
    logic [ADDR_BITS-1:0] f_tag;
    logic [QW-1:0]        q_data;
    t_cmd                 b_cmd;
    logic [SIW-1:0]       b_set;
    logic [ADDR_BITS-1:0] b_tag;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_bits   <= 3'd0;
            r_cfg.ways       <= 3'd1;
            r_cfg.block_bits <= 5'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SET_BITS:   r_cfg.set_bits   <= i_cfg_data[2:0];
                REG_WAYS:       r_cfg.ways       <= i_cfg_data[2:0];
                REG_BLOCK_BITS: r_cfg.block_bits <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    salru_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .ADDR_BITS    (ADDR_BITS),
        .SIW          (SIW)
    ) u_front (
        .i_req      (i_req),
        .i_cfg      (r_cfg),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (f_cmd),
        .o_set      (f_set),
        .o_tag      (f_tag)
    );

    salru_queue #(
        .W     (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_set, f_tag}),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    assign {b_cmd, b_set, b_tag} = q_data;

    salru_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_BITS    (ADDR_BITS),
        .SIW          (SIW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_cmd      (b_cmd),
        .i_set      (b_set),
        .i_tag      (b_tag),
        .o_q_pop    (pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );

endmodule

// ===== sv/salru_front.sv =====
// Front end: takes request words and splits the address into set and tag.
// Depends on salru_pkg and salru_in_if.
module salru_front #(
    parameter int MAX_SET_BITS = 6,
    parameter int ADDR_BITS    = 32,
    parameter int SIW          = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    salru_in_if.sink               i_req,
    input  salru_pkg::t_cfg        i_cfg,
    input  logic                   i_clearing,
    input  logic                   i_q_full,
    output logic                   o_push,
    output salru_pkg::t_cmd        o_cmd,
    output logic [SIW-1:0]         o_set,
    output logic [ADDR_BITS-1:0]   o_tag
);
    import salru_pkg::*;

    localparam int SHW = 4;

    logic [ADDR_BITS-1:0] addr_x;
    logic [ADDR_BITS-1:0] block;
    logic [SHW-1:0]       set_sh;
    logic [SIW-1:0]       set_mask;

    // no words taken while the line store is being cleared
    assign i_req.ready = !i_q_full && !i_clearing;
    assign o_push      = i_req.valid && i_req.ready;
    assign o_cmd       = i_req.command;

    // drop block offset, clamp set bit count, split set and tag
    always_comb begin
        addr_x   = ADDR_BITS'(i_req.address);
        block    = addr_x >> i_cfg.block_bits;
        set_sh   = (i_cfg.set_bits > MAX_SET_BITS) ? SHW'(MAX_SET_BITS)
                                                   : SHW'(i_cfg.set_bits);
        set_mask = ~({SIW{1'b1}} << set_sh);
        o_set    = (MAX_SET_BITS == 0) ? '0 : (SIW'(block) & set_mask);
        o_tag    = block >> set_sh;
    end

endmodule

// ===== sv/salru_queue.sv =====
// Short FIFO between the front end and the lookup engine.
// Depends on nothing.
module salru_queue #(
    parameter int W     = 40,
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [W-1:0]  i_data,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output logic [W-1:0]  o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_buf [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_data  = r_buf[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/salru_back.sv =====
// Lookup engine: set memory read, tag compare, LRU update and totals.
// Depends on salru_pkg and salru_out_if.
module salru_back #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 4,
    parameter int ADDR_BITS    = 32,
    parameter int SIW          = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  salru_pkg::t_cfg       i_cfg,
    input  logic                  i_q_valid,
    input  salru_pkg::t_cmd       i_cmd,
    input  logic [SIW-1:0]        i_set,
    input  logic [ADDR_BITS-1:0]  i_tag,
    output logic                  o_q_pop,
    output logic                  o_clearing,
    salru_out_if.source           o_rsp
);
    import salru_pkg::*;

    localparam int SETS  = 2 ** MAX_SET_BITS;
    localparam int TW    = ADDR_BITS;
    localparam int LW    = TW + 3;            // tag, age, valid per way
    localparam int ROW_W = MAX_WAYS * LW;
    localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCW   = $clog2(MAX_WAYS + 1);
    localparam logic [SIW-1:0] CLR_LAST = SIW'(SETS - 1);

    typedef enum logic [1:0] {S_CLEAR, S_ISSUE, S_EVAL} t_state;

    t_state              r_state;
    logic [SIW-1:0]      r_clr;
    t_cmd                r_cmd;
    logic [SIW-1:0]      r_set;
    logic [TW-1:0]       r_tag;
    logic [ROW_W-1:0]    r_row;
    logic [ROW_W-1:0]    r_mem [SETS];
    logic                r_out_valid;
    logic [1:0]          r_out_hits;
    logic                r_out_miss;
    logic                r_out_evict;
    logic [CNT_W-1:0]    r_tot_hits;
    logic [CNT_W-1:0]    r_tot_misses;
    logic [CNT_W-1:0]    r_tot_evicts;

    logic                out_free;
    logic                n_out_valid;
    logic                is_acc;
    logic                is_mod;
    logic [WCW-1:0]      nways;
    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] way_v;
    t_age                way_age [MAX_WAYS];
    logic [TW-1:0]       way_tag [MAX_WAYS];
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] inv_vec;
    logic [MAX_WAYS-1:0] age_vec [4];
    logic [MAX_WAYS-1:0] lru_vec;
    logic [WW-1:0]       hit_idx;
    logic [WW-1:0]       inv_idx;
    logic [WW-1:0]       lru_idx;
    logic [WW-1:0]       sel_way;
    logic                any_hit;
    logic                any_inv;
    t_age                old_age;
    logic [ROW_W-1:0]    n_row;
    logic [1:0]          n_hits;
    logic                n_miss;
    logic                n_evict;
    logic [CNT_W:0]      sum_hits;
    logic [CNT_W:0]      sum_misses;
    logic [CNT_W:0]      sum_evicts;
    logic                mem_we;
    logic [SIW-1:0]      mem_wa;
    logic [ROW_W-1:0]    mem_wd;

    assign out_free   = !r_out_valid || o_rsp.ready;
    assign o_q_pop    = (r_state == S_ISSUE) && i_q_valid;
    assign o_clearing = (r_state == S_CLEAR);

    // result word loads on evaluation, holds while the receiver stalls
    assign n_out_valid = ((r_state == S_EVAL) && out_free) || (r_out_valid && !o_rsp.ready);

    // command decode
    always_comb begin
        unique case (r_cmd) inside
            CMD_LOAD, CMD_STORE: begin
                is_acc = 1'b1;
                is_mod = 1'b0;
            end
            CMD_MODIFY: begin
                is_acc = 1'b1;
                is_mod = 1'b1;
            end
            default: begin
                is_acc = 1'b0;
                is_mod = 1'b0;
            end
        endcase
    end

    // ways in use: zero reads as one, clamp at the built size
    always_comb begin
        if (i_cfg.ways == 3'd0) begin
            nways = WCW'(1);
        end else if (i_cfg.ways > MAX_WAYS) begin
            nways = WCW'(MAX_WAYS);
        end else begin
            nways = WCW'(i_cfg.ways);
        end
    end

    // unpack the row and classify each way
    always_comb begin
        for (int a = 0; a < 4; a++) begin
            age_vec[a] = '0;
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            way_tag[i] = r_row[i*LW +: TW];
            way_age[i] = r_row[i*LW + TW +: 2];
            way_v[i]   = r_row[i*LW + TW + 2];
            in_use[i]  = (WCW'(i) < nways);
            hit_vec[i] = in_use[i] && way_v[i] && (way_tag[i] == r_tag);
            inv_vec[i] = in_use[i] && !way_v[i];
            for (int a = 0; a < 4; a++) begin
                age_vec[a][i] = in_use[i] && way_v[i] && (way_age[i] == 2'(a));
            end
        end
    end

    // oldest age level present, then lowest way of each class
    always_comb begin
        lru_vec = '0;
        for (int a = 0; a < 4; a++) begin
            if (|age_vec[a]) begin
                lru_vec = age_vec[a];
            end
        end
        hit_idx = '0;
        inv_idx = '0;
        lru_idx = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = WW'(i);
            end
            if (inv_vec[i]) begin
                inv_idx = WW'(i);
            end
            if (lru_vec[i]) begin
                lru_idx = WW'(i);
            end
        end
        any_hit = |hit_vec;
        any_inv = |inv_vec;
    end

    // chosen way, its old age, and the updated row
    always_comb begin
        if (any_hit) begin
            sel_way = hit_idx;
            old_age = way_age[hit_idx];
        end else if (any_inv) begin
            sel_way = inv_idx;
            old_age = AGE_MAX;
        end else begin
            sel_way = lru_idx;
            old_age = way_age[lru_idx];
        end
        n_row = r_row;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (WW'(i) == sel_way) begin
                n_row[i*LW +: TW]     = r_tag;
                n_row[i*LW + TW +: 2] = '0;
                n_row[i*LW + TW + 2]  = 1'b1;
            end else if (in_use[i] && way_v[i] && (way_age[i] < old_age)
                         && (way_age[i] != AGE_MAX)) begin
                n_row[i*LW + TW +: 2] = way_age[i] + 2'd1;
            end
        end
    end

    // per-word counts; second half of a modify always hits the fresh line
    always_comb begin
        n_hits     = {1'b0, is_acc && any_hit} + {1'b0, is_mod};
        n_miss     = is_acc && !any_hit;
        n_evict    = is_acc && !any_hit && !any_inv;
        sum_hits   = {1'b0, r_tot_hits} + (CNT_W+1)'(n_hits);
        sum_misses = {1'b0, r_tot_misses} + (CNT_W+1)'(n_miss);
        sum_evicts = {1'b0, r_tot_evicts} + (CNT_W+1)'(n_evict);
    end

    // memory write port: clearing sweep or write-back
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_set;
        mem_wd = n_row;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = '0;
        end else if (r_state == S_EVAL && out_free && is_acc) begin
            mem_we = 1'b1;
        end
    end

    // set memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (o_q_pop) begin
            r_row <= r_mem[i_set];
        end
    end

    // sequencer, result register and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_tot_hits   <= '0;
            r_tot_misses <= '0;
            r_tot_evicts <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_cmd;
                        r_set   <= i_set;
                        r_tag   <= i_tag;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (out_free) begin
                        r_out_hits   <= n_hits;
                        r_out_miss   <= n_miss;
                        r_out_evict  <= n_evict;
                        r_tot_hits   <= sum_hits[CNT_W] ? '1 : sum_hits[CNT_W-1:0];
                        r_tot_misses <= sum_misses[CNT_W] ? '1 : sum_misses[CNT_W-1:0];
                        r_tot_evicts <= sum_evicts[CNT_W] ? '1 : sum_evicts[CNT_W-1:0];
                        r_state      <= S_ISSUE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.hit_count       = r_out_hits;
    assign o_rsp.missed          = r_out_miss;
    assign o_rsp.evicted         = r_out_evict;
    assign o_rsp.total_hits      = r_tot_hits;
    assign o_rsp.total_misses    = r_tot_misses;
    assign o_rsp.total_evictions = r_tot_evicts;

endmodule

// ===== sv/salru_checker.sv =====
// Port-level checks on the result channel of the cache tracker, and the
// bind that attaches them. Depends on salru_pkg and assert_macros.svh.
`include "assert_macros.svh"

module salru_assertions (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [1:0]                 i_hit_count,
    input logic                       i_missed,
    input logic                       i_evicted,
    input logic [salru_pkg::CNT_W-1:0] i_total_hits,
    input logic [salru_pkg::CNT_W-1:0] i_total_misses,
    input logic [salru_pkg::CNT_W-1:0] i_total_evictions
);

    // a word never reports more than two hits, nor a miss beside two hits
    property p_hit_range;
        i_valid |-> (i_hit_count != 2'd3) && !(i_missed && (i_hit_count == 2'd2));
    endproperty

    // totals never go backwards
    property p_tot_mono;
        i_valid |=> (i_total_hits >= $past(i_total_hits))
            && (i_total_misses >= $past(i_total_misses))
            && (i_total_evictions >= $past(i_total_evictions));
    endproperty

    // a stalled word holds
    property p_hold;
        i_valid && !i_ready |=> i_valid && $stable(i_hit_count) && $stable(i_total_hits);
    endproperty

    // nothing comes out in the cycle after reset
    `SALRU_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !i_valid, "result after reset")

    `SALRU_ASSERT(a_hit_range, i_clk, i_rst_n, p_hit_range, "bad hit count")

    // an eviction only happens on a miss
    `SALRU_ASSERT(a_evict_miss, i_clk, i_rst_n, i_valid && i_evicted |-> i_missed, "bad evict")

    `SALRU_ASSERT(a_tot_mono, i_clk, i_rst_n, p_tot_mono, "total decreased")

    `SALRU_ASSERT(a_hold, i_clk, i_rst_n, p_hold, "stalled word changed")

endmodule

bind set_assoc_lru_cache_tracker_top salru_assertions u_salru_assertions (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_rsp.valid),
    .i_ready           (o_rsp.ready),
    .i_hit_count       (o_rsp.hit_count),
    .i_missed          (o_rsp.missed),
    .i_evicted         (o_rsp.evicted),
    .i_total_hits      (o_rsp.total_hits),
    .i_total_misses    (o_rsp.total_misses),
    .i_total_evictions (o_rsp.total_evictions)
);
